@@ hdl/sorted_keyframe_table_top_defines.svh @@
// Assertion macros shared by the keyframe table RTL.
`ifndef SORTED_KEYFRAME_TABLE_TOP_DEFINES_SVH
`define SORTED_KEYFRAME_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define SKT_CHECK(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define SKT_CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/skt_pkg.sv @@
// Types and constants of the sorted keyframe table.
`default_nettype none

package skt_pkg;

  localparam int KEY_W   = 32;
  localparam int CRD_W   = 32;
  localparam int PT_W    = 3 * CRD_W;
  localparam int ENT_W   = KEY_W + PT_W;
  localparam int KIND_W  = 4;
  localparam int STAT_W  = 2;
  localparam int RANK_W  = 6;
  localparam int MAX_OUT = 32;

  localparam logic [KIND_W-1:0] KIND_INSERT = 4'd0;
  localparam logic [KIND_W-1:0] KIND_REKEY  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_PRED   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_SUCC   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RANK   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_SET    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 4'd8;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PRESENT   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_NONE = -32'sd1;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] key_out;
    logic [RANK_W-1:0]       rank_out;
    logic [CRD_W-1:0]        x_out;
    logic [CRD_W-1:0]        y_out;
    logic [CRD_W-1:0]        z_out;
    logic                    last;
  } skt_res_t;

  typedef struct packed {
    logic     valid;
    skt_res_t res;
  } skt_push_t;

endpackage

`default_nettype wire

@@ hdl/skt_ifs.sv @@
// Valid/ready channel interfaces for the keyframe table's operations and results.
`default_nettype none

interface skt_in_if import skt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] new_key;
  logic [CRD_W-1:0]        x_bits;
  logic [CRD_W-1:0]        y_bits;
  logic [CRD_W-1:0]        z_bits;

  modport source (output valid, kind, key, new_key, x_bits, y_bits, z_bits, input ready);
  modport sink   (input valid, kind, key, new_key, x_bits, y_bits, z_bits, output ready);
endinterface

interface skt_out_if import skt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [KEY_W-1:0] key_out;
  logic [RANK_W-1:0]       rank_out;
  logic [CRD_W-1:0]        x_out;
  logic [CRD_W-1:0]        y_out;
  logic [CRD_W-1:0]        z_out;
  logic                    last;

  modport source (output valid, status, key_out, rank_out, x_out, y_out, z_out, last,
                  input ready);
  modport sink   (input valid, status, key_out, rank_out, x_out, y_out, z_out, last,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/skt_ctrl.sv @@
// Sequencer, entry memory and shared key comparator of the keyframe table.
`default_nettype none

module skt_ctrl import skt_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  skt_in_if.sink       in_ch,
  input  wire logic    room,
  output skt_push_t    push,
  output logic [CW-1:0] count
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_SEARCH   = 12'b0000_0000_0010,
    S_SRCH_CMP = 12'b0000_0000_0100,
    S_EXEC     = 12'b0000_0000_1000,
    S_SHUP     = 12'b0000_0001_0000,
    S_INS      = 12'b0000_0010_0000,
    S_SHDN     = 12'b0000_0100_0000,
    S_RMDONE   = 12'b0000_1000_0000,
    S_SUCC     = 12'b0001_0000_0000,
    S_DUMP_RD  = 12'b0010_0000_0000,
    S_DUMP_GET = 12'b0100_0000_0000,
    S_EMIT     = 12'b1000_0000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [KIND_W-1:0]       op_r, op_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] nkey_r, nkey_nxt;
  logic [PT_W-1:0]         pt_r, pt_nxt;
  logic signed [KEY_W-1:0] prev_r, prev_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic                    found_r, found_nxt;
  logic                    rk_r, rk_nxt;
  logic                    more_r, more_nxt;
  skt_res_t                res_r, res_nxt;

  logic [ENT_W-1:0] mem_r [DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;

  logic signed [KEY_W-1:0] rd_key;
  logic                    key_lt;
  logic                    key_eq;
  logic [CW:0]             idx_p1;
  logic [CW:0]             idx_p2;
  logic [CW-1:0]           idx_m1;
  logic [CW-1:0]           idx_m2;
  logic [CW:0]             pos_p1;
  logic [CW:0]             cnt_x;
  logic [CW-1:0]           cnt_m1;
  logic                    dump_last;
  skt_res_t                res_blank;

  // Shared comparator: the entry just read against the key being searched.
  assign rd_key = rd_data_r[ENT_W-1 -: KEY_W];
  assign key_lt = rd_key < key_r;
  assign key_eq = rd_key == key_r;

  assign idx_p1 = {1'b0, idx_r} + (CW + 1)'(1);
  assign idx_p2 = {1'b0, idx_r} + (CW + 1)'(2);
  assign idx_m1 = idx_r - CW'(1);
  assign idx_m2 = idx_r - CW'(2);
  assign pos_p1 = {1'b0, pos_r} + (CW + 1)'(1);
  assign cnt_x  = {1'b0, cnt_r};
  assign cnt_m1 = cnt_r - CW'(1);
  assign dump_last = (idx_p1 == cnt_x) || (32'(idx_p1) == MAX_OUT);

  always_comb begin
    res_blank      = '0;
    res_blank.last = 1'b1;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign push.valid  = (state_r == S_EMIT);
  assign push.res    = res_r;
  assign count       = cnt_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    nkey_nxt  = nkey_r;
    pt_nxt    = pt_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    rk_nxt    = rk_r;
    more_nxt  = more_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = pos_r[AW-1:0];
    wr_data   = {key_r, pt_r};

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = in_ch.kind;
          key_nxt  = in_ch.key;
          nkey_nxt = in_ch.new_key;
          pt_nxt   = {in_ch.x_bits, in_ch.y_bits, in_ch.z_bits};
          rk_nxt   = 1'b0;
          more_nxt = 1'b0;
          res_nxt  = res_blank;
          if (in_ch.kind == KIND_CLEAR) begin
            cnt_nxt   = '0;
            state_nxt = S_EMIT;
          end else if (in_ch.kind == KIND_DUMP) begin
            idx_nxt = '0;
            if (cnt_r == '0) begin
              res_nxt.status = STAT_NOT_FOUND;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_DUMP_RD;
            end
          end else if (in_ch.kind inside {KIND_INSERT, KIND_REKEY, KIND_PRED, KIND_SUCC,
                                          KIND_DELETE, KIND_RANK, KIND_SET}) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_SEARCH: begin
        if (cnt_r == '0) begin
          pos_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_EXEC;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          idx_nxt   = '0;
          state_nxt = S_SRCH_CMP;
        end
      end

      // One entry per cycle: compare the entry at idx while fetching idx + 1.
      S_SRCH_CMP: begin
        if (key_lt) begin
          prev_nxt = rd_key;
          idx_nxt  = idx_p1[CW-1:0];
          if (idx_p1 == cnt_x) begin
            pos_nxt   = idx_p1[CW-1:0];
            found_nxt = 1'b0;
            state_nxt = S_EXEC;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_p1[AW-1:0];
          end
        end else begin
          pos_nxt   = idx_r;
          found_nxt = key_eq;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt   = res_blank;
        state_nxt = S_EMIT;
        case (op_r)
          KIND_INSERT: begin
            if (found_r) begin
              res_nxt.status = STAT_PRESENT;
            end else if (cnt_r == CW'(DEPTH)) begin
              res_nxt.status = STAT_FULL;
            end else if (pos_r == cnt_r) begin
              state_nxt = S_INS;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = cnt_m1[AW-1:0];
              idx_nxt   = cnt_r;
              state_nxt = S_SHUP;
            end
          end
          KIND_REKEY, KIND_DELETE: begin
            if (!found_r) begin
              res_nxt.status = STAT_NOT_FOUND;
            end else begin
              if (op_r == KIND_REKEY) begin
                // The entry leaves, then is inserted under the new key with its payload; a taken new key drops it.
                pt_nxt  = rd_data_r[PT_W-1:0];
                key_nxt = nkey_r;
                op_nxt  = KIND_INSERT;
                rk_nxt  = 1'b1;
              end
              if (pos_p1 < cnt_x) begin
                rd_en     = 1'b1;
                rd_addr   = pos_p1[AW-1:0];
                idx_nxt   = pos_r;
                state_nxt = S_SHDN;
              end else begin
                state_nxt = S_RMDONE;
              end
            end
          end
          KIND_PRED: begin
            if (pos_r != '0) begin
              res_nxt.key_out = prev_r;
            end else begin
              res_nxt.status = STAT_NOT_FOUND;
            end
          end
          KIND_SUCC: begin
            res_nxt.key_out = KEY_NONE;
            if (!found_r) begin
              res_nxt.status = STAT_NOT_FOUND;
            end else if (pos_p1 < cnt_x) begin
              rd_en     = 1'b1;
              rd_addr   = pos_p1[AW-1:0];
              state_nxt = S_SUCC;
            end
          end
          KIND_RANK: begin
            if (found_r) begin
              res_nxt.rank_out = RANK_W'(pos_r);
            end else begin
              res_nxt.rank_out = RANK_W'(cnt_r);
              res_nxt.status   = STAT_NOT_FOUND;
            end
          end
          KIND_SET: begin
            if (found_r) begin
              wr_en   = 1'b1;
              wr_addr = pos_r[AW-1:0];
            end else begin
              res_nxt.status = STAT_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end

      // Move entries up by one, top first, one per cycle.
      S_SHUP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data_r;
        idx_nxt = idx_m1;
        if (idx_m1 == pos_r) begin
          state_nxt = S_INS;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_m2[AW-1:0];
        end
      end

      S_INS: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[AW-1:0];
        cnt_nxt   = cnt_r + CW'(1);
        res_nxt   = res_blank;
        state_nxt = S_EMIT;
      end

      // Move entries down by one over the removed slot.
      S_SHDN: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data_r;
        idx_nxt = idx_p1[CW-1:0];
        if (idx_p2 < cnt_x) begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[AW-1:0];
        end else begin
          state_nxt = S_RMDONE;
        end
      end

      S_RMDONE: begin
        cnt_nxt = cnt_m1;
        if (rk_r) begin
          rk_nxt    = 1'b0;
          state_nxt = S_SEARCH;
        end else begin
          res_nxt   = res_blank;
          state_nxt = S_EMIT;
        end
      end

      S_SUCC: begin
        res_nxt         = res_blank;
        res_nxt.key_out = rd_key;
        state_nxt       = S_EMIT;
      end

      S_DUMP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r[AW-1:0];
        state_nxt = S_DUMP_GET;
      end

      S_DUMP_GET: begin
        res_nxt.status   = STAT_OK;
        res_nxt.key_out  = rd_key;
        res_nxt.rank_out = '0;
        res_nxt.x_out    = rd_data_r[PT_W-1 -: CRD_W];
        res_nxt.y_out    = rd_data_r[2*CRD_W-1 -: CRD_W];
        res_nxt.z_out    = rd_data_r[CRD_W-1:0];
        res_nxt.last     = dump_last;
        more_nxt         = !dump_last;
        idx_nxt          = idx_p1[CW-1:0];
        state_nxt        = S_EMIT;
      end

      S_EMIT: begin
        if (room) begin
          state_nxt = more_r ? S_DUMP_RD : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rk_r    <= 1'b0;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rk_r    <= rk_nxt;
      more_r  <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    nkey_r  <= nkey_nxt;
    pt_r    <= pt_nxt;
    prev_r  <= prev_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/skt_outbuf.sv @@
// Output register of the keyframe table's result channel.
`default_nettype none

module skt_outbuf import skt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire skt_push_t push,
  output logic           room,
  skt_out_if.source      out_ch
);

  logic     valid_r;
  skt_res_t data_r;

  assign room = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push.valid && room) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && room) begin
      data_r <= push.res;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.status   = data_r.status;
  assign out_ch.key_out  = data_r.key_out;
  assign out_ch.rank_out = data_r.rank_out;
  assign out_ch.x_out    = data_r.x_out;
  assign out_ch.y_out    = data_r.y_out;
  assign out_ch.z_out    = data_r.z_out;
  assign out_ch.last     = data_r.last;

endmodule

`default_nettype wire

@@ hdl/sorted_keyframe_table_top.sv @@
// Top level of the sorted keyframe table.
//
// The table holds up to DEPTH signed keys in ascending order, each with a
// 96-bit point payload. An operation enters on in_ch (valid/ready); its
// results leave on out_ch (valid/ready), and the final result of each
// operation carries last. Dump gives one result per stored entry, capped at
// 32; every other operation gives exactly one result.
// The block works on one operation at a time: in_ch.ready is high only while
// the sequencer is idle. A search compares one stored key per cycle, and an
// insert or delete then moves one entry per cycle through the entry memory.
// A rekey is a delete followed by an insert, and a dump reads each entry and
// hands it to the output register before it reads the next one.
// Results pass through an output register, so the next transfer on in_ch is
// taken while the last result still waits on out_ch. A stalled receiver holds
// the sequencer only when it has a further result to hand over.
// Synchronous reset empties the table at once; stored entries are not
// cleared because entries at or above the entry count are never read.
`default_nettype none
`include "sorted_keyframe_table_top_defines.svh"

module sorted_keyframe_table_top import skt_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  skt_in_if.sink    in_ch,
  skt_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);

  skt_push_t     push;
  logic          room;
  logic [CW-1:0] count;

  skt_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push),
    .count (count)
  );

  skt_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

  // The entry count never runs past the table size.
  `SKT_CHECK(a_count_range, 1'b1, count <= DEPTH, "entry count exceeds table depth")

  // An accepted operation makes the sequencer busy: in_ch.ready is low right after the transfer.
  `SKT_CHECK_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
                  "input taken again right after a transfer")

  // While a non-final dump result waits, the dump is still in progress.
  `SKT_CHECK(a_dump_in_flight, out_ch.valid && !out_ch.last, !in_ch.ready,
             "sequencer idle with a dump unfinished")

endmodule

`default_nettype wire

@@ tb/sorted_keyframe_table_checker.sv @@
// Scoreboard for the keyframe table: predicts every result and compares it on the out channel.
`timescale 1ns / 100ps
`default_nettype none

module sorted_keyframe_table_checker import skt_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  skt_in_if         in_mon,
  skt_out_if        out_mon,
  output int        fail_count,
  output int        open_count,
  output int        checked_count
);

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [CRD_W-1:0]        x;
    logic [CRD_W-1:0]        y;
    logic [CRD_W-1:0]        z;
  } frame_t;

  // Shadow of the table contents in ascending key order.
  frame_t   frames[$];
  skt_res_t awaited[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       pending = 0;

  assign fail_count    = mismatches;
  assign open_count    = pending;
  assign checked_count = results_seen;

  // Index of the first stored key that is not below k.
  function automatic int lower_index(input logic signed [KEY_W-1:0] k);
    int i;
    i = 0;
    while (i < frames.size() && $signed(frames[i].key) < k) i++;
    return i;
  endfunction

  task automatic apply_op(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] k,
                          input logic signed [KEY_W-1:0] nk,
                          input logic [CRD_W-1:0] x, input logic [CRD_W-1:0] y,
                          input logic [CRD_W-1:0] z);
    skt_res_t r;
    frame_t   f;
    int       p;
    int       n;
    bit       hit;
    r = '0;
    r.last = 1'b1;
    p = lower_index(k);
    hit = (p < frames.size()) && (frames[p].key == k);
    case (kind)
      KIND_INSERT: begin
        if (hit) r.status = STAT_PRESENT;
        else if (frames.size() >= DEPTH) r.status = STAT_FULL;
        else begin
          f = '{key: k, x: x, y: y, z: z};
          frames.insert(p, f);
        end
      end
      KIND_REKEY: begin
        if (!hit) r.status = STAT_NOT_FOUND;
        else begin
          f = frames[p];
          frames.delete(p);
          p = lower_index(nk);
          // A taken destination drops the moved entry altogether.
          if (p < frames.size() && frames[p].key == nk) r.status = STAT_PRESENT;
          else begin
            f.key = nk;
            frames.insert(p, f);
          end
        end
      end
      KIND_PRED: begin
        if (p > 0) r.key_out = frames[p-1].key;
        else r.status = STAT_NOT_FOUND;
      end
      KIND_SUCC: begin
        r.key_out = KEY_NONE;
        if (!hit) r.status = STAT_NOT_FOUND;
        else if (p + 1 < frames.size()) r.key_out = frames[p+1].key;
      end
      KIND_DELETE: begin
        if (hit) frames.delete(p);
        else r.status = STAT_NOT_FOUND;
      end
      KIND_RANK: begin
        if (hit) r.rank_out = RANK_W'(p);
        else begin
          r.rank_out = RANK_W'(frames.size());
          r.status = STAT_NOT_FOUND;
        end
      end
      KIND_SET: begin
        if (hit) begin
          f = frames[p];
          f.x = x;
          f.y = y;
          f.z = z;
          frames[p] = f;
        end else r.status = STAT_NOT_FOUND;
      end
      KIND_CLEAR: frames.delete();
      KIND_DUMP: begin
        n = (frames.size() < MAX_OUT) ? frames.size() : MAX_OUT;
        if (n == 0) r.status = STAT_NOT_FOUND;
        else begin
          for (int i = 0; i < n; i++) begin
            r = '0;
            r.key_out = frames[i].key;
            r.x_out = frames[i].x;
            r.y_out = frames[i].y;
            r.z_out = frames[i].z;
            r.last = (i + 1 == n);
            awaited.push_back(r);
            pending++;
          end
          return;
        end
      end
      default: ;
    endcase
    awaited.push_back(r);
    pending++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: result %0d field %s mismatch: expected %h, got %h",
               $time, results_seen, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    skt_res_t want;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result: status %h key %h rank %h last %b", $time,
               out_mon.status, out_mon.key_out, out_mon.rank_out, out_mon.last);
      mismatches++;
    end else begin
      want = awaited.pop_front();
      pending--;
      compare_field("status", 32'(want.status), 32'(out_mon.status));
      compare_field("key_out", want.key_out, out_mon.key_out);
      compare_field("rank_out", 32'(want.rank_out), 32'(out_mon.rank_out));
      compare_field("x_out", want.x_out, out_mon.x_out);
      compare_field("y_out", want.y_out, out_mon.y_out);
      compare_field("z_out", want.z_out, out_mon.z_out);
      compare_field("last", 32'(want.last), 32'(out_mon.last));
    end
    results_seen++;
  endtask

  // Results are checked before the new operation is predicted; a result can
  // never belong to an operation accepted on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        apply_op(in_mon.kind, in_mon.key, in_mon.new_key, in_mon.x_bits, in_mon.y_bits,
                 in_mon.z_bits);
    end
  end

endmodule

`default_nettype wire

@@ tb/sorted_keyframe_table_top_tb.sv @@
// Testbench top of the keyframe table: clock, reset, operation stimulus and the verdict.
`timescale 1ns / 100ps
`default_nettype none

module sorted_keyframe_table_top_tb;
  import skt_pkg::*;

  localparam int DEPTH       = 32;
  localparam int ITEM_TARGET = 470;
  localparam int POOL_SIZE   = 48;
  // The fill run walks more pool keys than the table can hold.
  localparam int FILL_KEYS   = 40;
  localparam int DRAIN_WAIT  = 4 * DEPTH + 30;
  // A hang guard only; a correct run needs a small fraction of this.
  localparam int CYCLE_LIMIT = 5_000_000;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic clk;
  logic rst_n;

  skt_in_if  in_ch();
  skt_out_if out_ch();

  int fail_count;
  int open_count;
  int checked_count;

  int ops_sent = 0;
  int directed_ops = 0;
  int phases_run = 0;
  int fills_run = 0;
  int cycles = 0;
  // While set, neither side idles; it only changes right after a rising edge.
  bit steady = 1'b0;

  logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

  sorted_keyframe_table_top #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_keyframe_table_checker #(.DEPTH(DEPTH)) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .checked_count (checked_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hang guard: any run that outlives the limit is a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, open_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle length shared by both sides: mostly none, otherwise a short or now and
  // then a long stretch; none at all while steady is set.
  function automatic int idle_cycles();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: ready alternates between open stretches and stalls. Dumps are
  // the interesting case, since a stall there holds the sequencer mid-walk.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= 1'b1;
      if (steady) repeat (50) @(negedge clk);
      else begin
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (idle_cycles()) @(negedge clk);
      end
    end
  end

  // Drives one operation at a falling edge and holds it until the transfer.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                         input logic signed [KEY_W-1:0] new_key,
                         input logic [CRD_W-1:0] x, input logic [CRD_W-1:0] y,
                         input logic [CRD_W-1:0] z);
    int gap;
    gap = idle_cycles();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.key     <= key;
    in_ch.new_key <= new_key;
    in_ch.x_bits  <= x;
    in_ch.y_bits  <= y;
    in_ch.z_bits  <= z;
    do @(posedge clk); while (!in_ch.ready);
    ops_sent++;
  endtask

  // Most keys come from a small pool so that lookups hit stored entries;
  // the rest are fully random and nearly always miss.
  function automatic logic signed [KEY_W-1:0] pool_key(input int span);
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, span - 1)];
    return $urandom;
  endfunction

  task automatic send_random_op(input int span);
    int                      pick;
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] k;
    logic signed [KEY_W-1:0] nk;
    pick = $urandom_range(0, 99);
    if (pick < 25) kind = KIND_INSERT;
    else if (pick < 35) kind = KIND_REKEY;
    else if (pick < 45) kind = KIND_PRED;
    else if (pick < 55) kind = KIND_SUCC;
    else if (pick < 65) kind = KIND_DELETE;
    else if (pick < 74) kind = KIND_RANK;
    else if (pick < 83) kind = KIND_SET;
    else if (pick < 85) kind = KIND_CLEAR;
    else if (pick < 93) kind = KIND_DUMP;
    else kind = KIND_DUMP + KIND_W'($urandom_range(1, 7));
    k = pool_key(span);
    // Now and then a rekey onto its own key.
    nk = ($urandom_range(0, 6) == 0) ? k : pool_key(span);
    send_op(kind, k, nk, $urandom, $urandom, $urandom);
  endtask

  // Well-formed run that fills the table: clear, then insert the first
  // FILL_KEYS pool keys in shuffled order. The inserts past DEPTH must report
  // a full table; a full dump and ten random operations on the fill keys follow.
  task automatic fill_table();
    int order[FILL_KEYS];
    int j;
    int t;
    for (int i = 0; i < FILL_KEYS; i++) order[i] = i;
    for (int i = FILL_KEYS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    send_op(KIND_CLEAR, '0, '0, '0, '0, '0);
    for (int i = 0; i < FILL_KEYS; i++)
      send_op(KIND_INSERT, key_pool[order[i]], '0, $urandom, $urandom, $urandom);
    send_op(KIND_DUMP, '0, '0, '0, '0, '0);
    repeat (10) send_random_op(FILL_KEYS);
    fills_run++;
  endtask

  // Pauses the sender until every predicted result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_INSERT;
    in_ch.key      = '0;
    in_ch.new_key  = '0;
    in_ch.x_bits   = '0;
    in_ch.y_bits   = '0;
    in_ch.z_bits   = '0;

    // Pool keys: the key extremes, zero and their neighbors, then random ones.
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = KEY_NONE;
    key_pool[4] = KEY_MIN + 1;
    key_pool[5] = KEY_MAX - 1;
    key_pool[6] = 1;
    key_pool[7] = -2;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Every query first meets the empty table.
    send_op(KIND_DUMP, '0, '0, '0, '0, '0);
    send_op(KIND_PRED, '0, '0, '0, '0, '0);
    send_op(KIND_SUCC, KEY_MAX, '0, '0, '0, '0);
    send_op(KIND_RANK, KEY_MIN, '0, '0, '0, '0);
    send_op(KIND_DELETE, '0, '0, '0, '0, '0);
    send_op(KIND_SET, KEY_MIN, '0, '1, '1, '1);
    send_op(KIND_REKEY, '0, KEY_MAX, '0, '0, '0);
    // Both key extremes with all-zero and all-one payloads.
    send_op(KIND_INSERT, KEY_MIN, KEY_MAX, '0, '0, '0);
    send_op(KIND_INSERT, KEY_MAX, KEY_MIN, '1, '1, '1);
    send_op(KIND_INSERT, '0, '1, 32'hAAAA_5555, 32'h5555_AAAA, 32'h8000_0001);
    send_op(KIND_INSERT, KEY_NONE, '0, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000);
    // Inserting a key that is already stored.
    send_op(KIND_INSERT, '0, '0, '1, '0, '1);
    // Nothing below the smallest key; the largest has no successor.
    send_op(KIND_PRED, KEY_MIN, '0, '0, '0, '0);
    send_op(KIND_PRED, KEY_MAX, '0, '0, '0, '0);
    send_op(KIND_SUCC, KEY_MAX, '0, '0, '0, '0);
    send_op(KIND_SUCC, KEY_MIN, '0, '0, '0, '0);
    send_op(KIND_RANK, KEY_MAX, '0, '0, '0, '0);
    send_op(KIND_RANK, 5, '0, '0, '0, '0);
    send_op(KIND_SET, '0, '0, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98);
    // Rekey onto a taken key drops the entry; onto itself keeps it.
    send_op(KIND_REKEY, '0, KEY_MAX, '0, '0, '0);
    send_op(KIND_REKEY, KEY_NONE, KEY_NONE, '0, '0, '0);
    send_op(KIND_REKEY, KEY_MIN, 5, '0, '0, '0);
    send_op(KIND_DELETE, KEY_MAX, '0, '0, '0, '0);
    send_op(KIND_DUMP, '0, '0, '0, '0, '0);
    // Codes above dump are undefined and must leave the table untouched.
    send_op(KIND_DUMP + 1, '1, '1, '1, '1, '1);
    send_op(KIND_DUMP + 7, '0, '0, '0, '0, '0);
    send_op(KIND_CLEAR, '0, '0, '0, '0, '0);
    send_op(KIND_DUMP, '0, '0, '0, '0, '0);
    directed_ops = ops_sent;
    drain();

    // Random part in phases: mixed traffic on a dense or a wide key set, and
    // every third phase a fill to capacity. Every other phase ends with the
    // sender holding off until all results are back.
    while (ops_sent < ITEM_TARGET) begin
      @(posedge clk);
      steady = ($urandom_range(0, 3) == 0);
      if (phases_run % 3 == 1) fill_table();
      else repeat (50) send_random_op(($urandom_range(0, 1) != 0) ? 8 : POOL_SIZE);
      if (phases_run % 2 == 0) drain();
      phases_run++;
    end

    drain();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Covered %0d operations (%0d directed) in %0d random phases, %0d filling the table.",
             ops_sent, directed_ops, phases_run, fills_run);
    $display("Checked %0d results field by field; %0d mismatches, %0d results never seen.",
             checked_count, fail_count, open_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
